>>> rtl/csvfu_pkg.sv
package csvfu_pkg;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharBrace  = 8'h7B;
  localparam logic [7:0] CharSingle = 8'h27;
  localparam logic [7:0] CharDouble = 8'h22;

  localparam logic [7:0] DelimReset  = 8'd44;
  localparam logic [7:0] EscapeReset = 8'd92;

  typedef enum logic [2:0] {
    ModeStart  = 3'd0,
    ModeUnq    = 3'd1,
    ModeOpened = 3'd2,
    ModeBrace  = 3'd3,
    ModeBody   = 3'd4,
    ModeEsc    = 3'd5,
    ModeQend   = 3'd6
  } parse_mode_e;

  typedef enum logic [1:0] {
    CauseDelim = 2'd0,
    CauseCr    = 2'd1,
    CauseLf    = 2'd2,
    CauseEoi   = 2'd3
  } end_cause_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegDelim      = 3'd0,
    RegAllowSq    = 3'd1,
    RegAllowDq    = 3'd2,
    RegEscEnable  = 3'd3,
    RegEscChar    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data;
    logic       field_end;
    end_cause_e cause;
  } result_t;

  function automatic result_t mk_res(logic [7:0] data, logic field_end, end_cause_e cause);
    result_t r;
    r.data      = data;
    r.field_end = field_end;
    r.cause     = cause;
    return r;
  endfunction

endpackage

>>> rtl/csv_field_unquoter_core.sv
// Channel   Direction  tdata        tuser                          tlast
// s_axis    in         in_byte      func                           -
// m_axis    out        out_byte     field_end, end_cause[1:0]      last_of_run
// cfg       in         write data   -                              -
//
// Each accepted byte is decoded in the cycle it arrives; its zero to two results are
// registered and leave one per cycle while the output is ready, starting the cycle
// after the transfer. A byte that yields one result sustains one byte per cycle while
// the output is ready; a byte with more results holds the input at the output port.
// Reset puts the parser at the start of a field and loads the register defaults.
// A stalled output keeps its data; the input is taken once the last result is leaving.
module csv_field_unquoter_core
  import csvfu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // [7:0] in_byte
  input  logic                   s_axis_tuser_i,   // [0] func
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [7:0]             m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0]             m_axis_tuser_o,   // [0] field_end, [2:1] end_cause
  output logic                   m_axis_tlast_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [7:0]             cfg_data_i
);

  logic [7:0] delim_q, esc_char_q;
  logic       allow_sq_q, allow_dq_q, esc_en_q;

  parse_mode_e mode_q, mode_d;
  logic        qd_q, qd_d, keep_q, keep_d;

  result_t res_q [MaxResults];
  result_t res_d [MaxResults];
  logic [1:0] cnt_q, cnt_d, rd_q;

  logic [7:0] b, cq;
  logic       func, is_term, brace_esc, bb_esc, bb_q, in_fire, out_fire;
  end_cause_e term_cause;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= DelimReset;
      allow_sq_q <= 1'b1;
      allow_dq_q <= 1'b1;
      esc_en_q   <= 1'b0;
      esc_char_q <= EscapeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDelim:     delim_q    <= cfg_data_i;
        RegAllowSq:   allow_sq_q <= cfg_data_i[0];
        RegAllowDq:   allow_dq_q <= cfg_data_i[0];
        RegEscEnable: esc_en_q   <= cfg_data_i[0];
        RegEscChar:   esc_char_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign b         = s_axis_tdata_i;
  assign func      = s_axis_tuser_i;
  assign cq        = qd_q ? CharDouble : CharSingle;
  assign brace_esc = esc_en_q && (esc_char_q == CharBrace);
  assign bb_esc    = esc_en_q && (b == esc_char_q);
  assign bb_q      = (b == cq);

  always_comb begin
    is_term    = 1'b1;
    term_cause = CauseDelim;
    if (b == delim_q) begin
      term_cause = CauseDelim;
    end else if (b == CharCr) begin
      term_cause = CauseCr;
    end else if (b == CharLf) begin
      term_cause = CauseLf;
    end else begin
      is_term = 1'b0;
    end
  end

  // Builds the result list of one byte; the quote and escape handling of the
  // body after an opening quote is shared through bb_esc and bb_q.
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = mk_res(8'h00, 1'b0, CauseDelim);
    end
    cnt_d  = 2'd0;
    mode_d = mode_q;
    qd_d   = qd_q;
    keep_d = keep_q;
    if (func) begin
      if (mode_q == ModeBrace && !brace_esc) begin
        res_d[cnt_d] = mk_res(CharBrace, 1'b0, CauseDelim);
        cnt_d = cnt_d + 2'd1;
      end
      if (mode_q == ModeQend && keep_q) begin
        res_d[cnt_d] = mk_res(cq, 1'b0, CauseDelim);
        cnt_d = cnt_d + 2'd1;
      end
      res_d[cnt_d] = mk_res(8'h00, 1'b1, CauseEoi);
      cnt_d  = cnt_d + 2'd1;
      mode_d = ModeStart;
      qd_d   = 1'b0;
      keep_d = 1'b0;
    end else begin
      case (mode_q)
        ModeStart: begin
          if (is_term) begin
            res_d[cnt_d] = mk_res(b, 1'b1, term_cause);
            cnt_d  = cnt_d + 2'd1;
            mode_d = ModeStart;
            qd_d   = 1'b0;
            keep_d = 1'b0;
          end else if (allow_sq_q && b == CharSingle) begin
            qd_d   = 1'b0;
            keep_d = 1'b0;
            mode_d = ModeOpened;
          end else if (allow_dq_q && b == CharDouble) begin
            qd_d   = 1'b1;
            keep_d = 1'b0;
            mode_d = ModeOpened;
          end else begin
            res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
            cnt_d  = cnt_d + 2'd1;
            mode_d = ModeUnq;
          end
        end
        ModeUnq: begin
          if (is_term) begin
            res_d[cnt_d] = mk_res(b, 1'b1, term_cause);
            cnt_d  = cnt_d + 2'd1;
            mode_d = ModeStart;
            qd_d   = 1'b0;
            keep_d = 1'b0;
          end else begin
            res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
            cnt_d = cnt_d + 2'd1;
          end
        end
        ModeOpened: begin
          if (b == CharBrace) begin
            mode_d = ModeBrace;
          end else if (bb_esc) begin
            mode_d = ModeEsc;
          end else if (bb_q) begin
            mode_d = ModeQend;
          end else begin
            res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
            cnt_d  = cnt_d + 2'd1;
            mode_d = ModeBody;
          end
        end
        ModeBrace: begin
          if (bb_q) begin
            keep_d = 1'b1;
            res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
            cnt_d = cnt_d + 2'd1;
          end
          if (brace_esc) begin
            if (bb_q || b == esc_char_q) begin
              res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
              cnt_d = cnt_d + 2'd1;
            end else begin
              res_d[cnt_d] = mk_res(esc_char_q, 1'b0, CauseDelim);
              cnt_d = cnt_d + 2'd1;
              res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
              cnt_d = cnt_d + 2'd1;
            end
            mode_d = ModeBody;
          end else begin
            res_d[cnt_d] = mk_res(CharBrace, 1'b0, CauseDelim);
            cnt_d = cnt_d + 2'd1;
            if (bb_esc) begin
              mode_d = ModeEsc;
            end else if (bb_q) begin
              mode_d = ModeQend;
            end else begin
              res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
              cnt_d  = cnt_d + 2'd1;
              mode_d = ModeBody;
            end
          end
        end
        ModeEsc: begin
          if (bb_q || b == esc_char_q) begin
            res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
            cnt_d = cnt_d + 2'd1;
          end else begin
            res_d[cnt_d] = mk_res(esc_char_q, 1'b0, CauseDelim);
            cnt_d = cnt_d + 2'd1;
            res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
            cnt_d = cnt_d + 2'd1;
          end
          mode_d = ModeBody;
        end
        ModeQend: begin
          if (is_term) begin
            if (keep_q) begin
              res_d[cnt_d] = mk_res(cq, 1'b0, CauseDelim);
              cnt_d = cnt_d + 2'd1;
            end
            res_d[cnt_d] = mk_res(b, 1'b1, term_cause);
            cnt_d  = cnt_d + 2'd1;
            mode_d = ModeStart;
            qd_d   = 1'b0;
            keep_d = 1'b0;
          end else begin
            res_d[cnt_d] = mk_res(cq, 1'b0, CauseDelim);
            cnt_d = cnt_d + 2'd1;
            if (bb_esc) begin
              mode_d = ModeEsc;
            end else if (bb_q) begin
              mode_d = ModeQend;
            end else begin
              res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
              cnt_d  = cnt_d + 2'd1;
              mode_d = ModeBody;
            end
          end
        end
        default: begin
          if (bb_esc) begin
            mode_d = ModeEsc;
          end else if (bb_q) begin
            mode_d = ModeQend;
          end else begin
            res_d[cnt_d] = mk_res(b, 1'b0, CauseDelim);
            cnt_d  = cnt_d + 2'd1;
            mode_d = ModeBody;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = (rd_q != cnt_q);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (rd_q == cnt_q) || ((rd_q + 2'd1 == cnt_q) && m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeStart;
      qd_q   <= 1'b0;
      keep_q <= 1'b0;
      cnt_q  <= 2'd0;
      rd_q   <= 2'd0;
    end else if (in_fire) begin
      mode_q <= mode_d;
      qd_q   <= qd_d;
      keep_q <= keep_d;
      cnt_q  <= cnt_d;
      rd_q   <= 2'd0;
    end else if (out_fire) begin
      rd_q <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tdata_o = res_q[rd_q].data;
  assign m_axis_tuser_o = {res_q[rd_q].cause, res_q[rd_q].field_end};
  assign m_axis_tlast_o = (rd_q + 2'd1 == cnt_q);

endmodule

>>> rtl/csvfu_checker.sv
module csvfu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [2:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // A field end is always the final result of its input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("field end without tlast");

  // End of input always produces a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> m_axis_tvalid_o)
    else $error("end of input gave no result");

  // With nothing pending the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked while output is empty");

  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output transfer changed");

endmodule

bind csv_field_unquoter_core csvfu_checker u_csvfu_checker (.*);
